// ----- design/gwm_pkg.sv -----
package gwm_pkg;

    // Wildcard and special characters
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FETCH,
        ST_EVAL,
        ST_TAIL_FETCH,
        ST_TAIL_EVAL
    } state_t;

    // Which verdict the datapath registers on emit
    typedef enum logic [1:0] {
        RES_SHORT,
        RES_FAIL,
        RES_TAIL
    } res_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load;
        logic     walk_init;
        logic     step;
        logic     tail_step;
        logic     emit;
        res_sel_t emit_sel;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic short_cut;
        logic name_done;
        logic step_fail;
        logic tail_more;
    } stat_t;

    // ASCII upper to lower case, other bytes unchanged
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

endpackage

// ----- design/gwm_ctrl.sv -----
module gwm_ctrl
    import gwm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  kind,
    input  logic  last,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && kind && last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = stat.short_cut ? ST_IDLE : ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = stat.name_done ? ST_TAIL_FETCH : ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = stat.step_fail ? ST_IDLE : ST_FETCH;
            end
            ST_TAIL_FETCH:
            begin
                state_next = ST_TAIL_EVAL;
            end
            ST_TAIL_EVAL:
            begin
                state_next = stat.tail_more ? ST_TAIL_FETCH : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd           = '0;
        cmd.emit_sel  = RES_SHORT;
        busy          = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_CHECK:
            begin
                cmd.emit      = stat.short_cut;
                cmd.emit_sel  = RES_SHORT;
                cmd.walk_init = !stat.short_cut;
            end
            ST_FETCH:
            begin
            end
            ST_EVAL:
            begin
                cmd.emit     = stat.step_fail;
                cmd.emit_sel = RES_FAIL;
                cmd.step     = !stat.step_fail;
            end
            ST_TAIL_FETCH:
            begin
            end
            ST_TAIL_EVAL:
            begin
                cmd.tail_step = stat.tail_more;
                cmd.emit      = !stat.tail_more;
                cmd.emit_sel  = RES_TAIL;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // A walk never starts from idle without a name end
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && state_next == ST_CHECK) |-> (start && kind && last))
        else $error("walk started without a name end");

    // Emit always returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == ST_IDLE))
        else $error("emit without return to idle");

    // Loading only happens in idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy)
        else $error("load while busy");

endmodule

// ----- design/gwm_dp.sv -----
module gwm_dp
    import gwm_pkg::*;
#(
    parameter int PATTERN_DEPTH = 64,
    parameter int NAME_DEPTH    = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output stat_t      stat,
    input  logic       kind,
    input  logic [7:0] char_code,
    input  logic       no_char,
    input  logic       last,
    output logic       matched,
    output logic       overflow,
    output logic       done
);

    localparam int PAW = $clog2(PATTERN_DEPTH);
    localparam int PLW = $clog2(PATTERN_DEPTH + 1);
    localparam int NAW = $clog2(NAME_DEPTH);
    localparam int NLW = $clog2(NAME_DEPTH + 1);

    // Stores
    logic [7:0] pat_mem [PATTERN_DEPTH];
    logic [7:0] name_mem [NAME_DEPTH];
    logic [7:0] p_rdata_reg;
    logic [7:0] n_rdata_reg;

    // String bookkeeping
    logic [PLW-1:0] plen_reg, plen_next;
    logic           popen_reg, popen_next;
    logic           ptl_reg, ptl_next;
    logic [2:0]     sds_reg, sds_next;
    logic [NLW-1:0] nlen_reg, nlen_next;
    logic           nopen_reg, nopen_next;
    logic           ntl_reg, ntl_next;

    // Walk registers
    logic [PLW-1:0] p_reg, p_next;
    logic [NLW-1:0] v_reg, v_next;
    logic [PLW-1:0] star_at_reg, star_at_next;
    logic [NLW-1:0] star_from_reg, star_from_next;
    logic           have_reg, have_next;

    // Result registers
    logic done_reg, done_next;
    logic matched_reg, matched_next;
    logic overflow_reg, overflow_next;

    logic [PLW-1:0] p_base;
    logic [NLW-1:0] n_base;
    logic           p_wr, n_wr;
    logic           p_valid, hit, star, ovf, sds;
    logic [7:0]     pc;

    // Base length of the string being loaded: a closed string restarts
    assign p_base = popen_reg ? plen_reg : '0;
    assign n_base = nopen_reg ? nlen_reg : '0;
    assign p_wr   = cmd.load && !kind && !no_char && (p_base < PLW'(PATTERN_DEPTH));
    assign n_wr   = cmd.load && kind && !no_char && (n_base < NLW'(NAME_DEPTH));

    // Loading
    always_comb
    begin
        plen_next  = plen_reg;
        popen_next = popen_reg;
        ptl_next   = ptl_reg;
        sds_next   = sds_reg;
        nlen_next  = nlen_reg;
        nopen_next = nopen_reg;
        ntl_next   = ntl_reg;
        if (cmd.load && !kind)
        begin
            plen_next  = p_base;
            ptl_next   = popen_reg ? ptl_reg : 1'b0;
            popen_next = !last;
            if (!no_char)
            begin
                if (p_wr)
                begin
                    plen_next = p_base + PLW'(1);
                end
                else
                begin
                    ptl_next = 1'b1;
                end
            end
            // Track the "*.*" special pattern on its first three characters
            if (p_wr && p_base == PLW'(0))
            begin
                sds_next[0] = (char_code == CH_STAR);
            end
            if (p_wr && p_base == PLW'(1))
            begin
                sds_next[1] = (char_code == CH_DOT);
            end
            if (p_wr && p_base == PLW'(2))
            begin
                sds_next[2] = (char_code == CH_STAR);
            end
        end
        if (cmd.load && kind)
        begin
            nlen_next  = n_base;
            ntl_next   = nopen_reg ? ntl_reg : 1'b0;
            nopen_next = !last;
            if (!no_char)
            begin
                if (n_wr)
                begin
                    nlen_next = n_base + NLW'(1);
                end
                else
                begin
                    ntl_next = 1'b1;
                end
            end
        end
    end

    // Store writes and registered reads at the walk pointers
    always_ff @(posedge clk)
    begin
        if (p_wr)
        begin
            pat_mem[p_base[PAW-1:0]] <= char_code;
        end
        if (n_wr)
        begin
            name_mem[n_base[NAW-1:0]] <= char_code;
        end
        p_rdata_reg <= pat_mem[p_reg[PAW-1:0]];
        n_rdata_reg <= name_mem[v_reg[NAW-1:0]];
    end

    // Compare of the fetched characters
    assign pc      = fold(p_rdata_reg);
    assign p_valid = p_reg < plen_reg;
    assign hit     = p_valid && (pc == CH_QMARK || pc == fold(n_rdata_reg));
    assign star    = p_valid && (pc == CH_STAR);
    assign ovf     = ptl_reg || ntl_reg;
    assign sds     = (plen_reg == PLW'(3)) && (&sds_reg);

    assign stat.short_cut = ovf || sds;
    assign stat.name_done = v_reg >= nlen_reg;
    assign stat.step_fail = !hit && !star && !have_reg;
    assign stat.tail_more = p_valid && (p_rdata_reg == CH_STAR);

    // Walk with backtracking to the last star
    always_comb
    begin
        p_next         = p_reg;
        v_next         = v_reg;
        star_at_next   = star_at_reg;
        star_from_next = star_from_reg;
        have_next      = have_reg;
        if (cmd.walk_init)
        begin
            p_next    = '0;
            v_next    = '0;
            have_next = 1'b0;
        end
        else if (cmd.step)
        begin
            if (hit)
            begin
                p_next = p_reg + PLW'(1);
                v_next = v_reg + NLW'(1);
            end
            else if (star)
            begin
                star_at_next   = p_reg;
                p_next         = p_reg + PLW'(1);
                star_from_next = v_reg;
                have_next      = 1'b1;
            end
            else
            begin
                p_next         = star_at_reg + PLW'(1);
                star_from_next = star_from_reg + NLW'(1);
                v_next         = star_from_reg + NLW'(1);
            end
        end
        else if (cmd.tail_step)
        begin
            p_next = p_reg + PLW'(1);
        end
    end

    // Verdict
    always_comb
    begin
        done_next     = cmd.emit;
        matched_next  = 1'b0;
        overflow_next = 1'b0;
        if (cmd.emit)
        begin
            case (cmd.emit_sel)
                RES_SHORT:
                begin
                    matched_next  = !ovf;
                    overflow_next = ovf;
                end
                RES_FAIL:
                begin
                    matched_next = 1'b0;
                end
                RES_TAIL:
                begin
                    matched_next = (p_reg == plen_reg);
                end
                default:
                begin
                    matched_next = 1'b0;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg  <= '0;
            popen_reg <= 1'b0;
            ptl_reg   <= 1'b0;
            sds_reg   <= '0;
            nlen_reg  <= '0;
            nopen_reg <= 1'b0;
            ntl_reg   <= 1'b0;
            have_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            plen_reg  <= plen_next;
            popen_reg <= popen_next;
            ptl_reg   <= ptl_next;
            sds_reg   <= sds_next;
            nlen_reg  <= nlen_next;
            nopen_reg <= nopen_next;
            ntl_reg   <= ntl_next;
            have_reg  <= have_next;
            done_reg  <= done_next;
        end
    end

    // Walk pointers and result payload
    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        v_reg         <= v_next;
        star_at_reg   <= star_at_next;
        star_from_reg <= star_from_next;
        matched_reg   <= matched_next;
        overflow_reg  <= overflow_next;
    end

    assign done     = done_reg;
    assign matched  = matched_reg;
    assign overflow = overflow_reg;

    // Overflow always forces no match
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(matched && overflow))
        else $error("match reported with overflow");

    // Lengths never exceed the store depths
    assert property (@(posedge clk) disable iff (!rst_n)
        (plen_reg <= PLW'(PATTERN_DEPTH)) && (nlen_reg <= NLW'(NAME_DEPTH)))
        else $error("length beyond store depth");

    // A step that consumes a name character keeps v within the name
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && hit) |=> (v_reg <= nlen_reg))
        else $error("name pointer ran past the name");

endmodule

// ----- design/glob_wildcard_matcher.sv -----
// Glob matcher with case folding. Pattern and name characters load one per
// cycle while busy is low (kind selects the store, no_char marks an item
// with no character). The item that ends a name starts a match walk during
// which busy is high: a check state, then a fetch and an eval state per walk
// step, then a tail fetch and a tail eval state that repeat per trailing star
// of the pattern, since each step reads both stores through their registered
// read ports. The verdict (matched, overflow) is presented for exactly one
// cycle with done, the cycle after the walk ends; it must be taken then.
// Overflow or the pattern "*.*" decide the result in the check state.
module glob_wildcard_matcher
    import gwm_pkg::*;
#(
    parameter int PATTERN_DEPTH = 64,
    parameter int NAME_DEPTH    = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       kind,
    input  logic [7:0] char_code,
    input  logic       no_char,
    input  logic       last,
    output logic       done,
    output logic       matched,
    output logic       overflow
);

    cmd_t  cmd;
    stat_t stat;

    gwm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .last  (last),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    gwm_dp #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .NAME_DEPTH    (NAME_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .kind      (kind),
        .char_code (char_code),
        .no_char   (no_char),
        .last      (last),
        .matched   (matched),
        .overflow  (overflow),
        .done      (done)
    );

    // A name end always makes the block busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind && last) |=> busy)
        else $error("name end did not start a walk");

    // Results come only out of a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a walk");

    // Results are never back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back to back results");

endmodule

// ----- sim/glob_match_checker.sv -----
module glob_match_checker
    import gwm_pkg::*;
#(
    parameter int PATTERN_DEPTH = 64,
    parameter int NAME_DEPTH    = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       kind,
    input  logic [7:0] char_code,
    input  logic       no_char,
    input  logic       last,
    input  logic       done,
    input  logic       matched,
    input  logic       overflow,
    output int         fail_count,
    output int         verdicts_owed
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_NAME    = 1'b1;

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    // Shadow copy of both stores
    logic [7:0] pat_mem [PATTERN_DEPTH];
    int         pat_len;
    bit         pat_open;
    bit         pat_ovf;
    logic [7:0] name_mem [NAME_DEPTH];
    int         name_len;
    bit         name_open;
    bit         name_ovf;

    verdict_t   owed_verdicts[$];
    int         errors = 0;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            return c | CASE_OFS;
        end
        return c;
    endfunction

    // Case-insensitive glob walk, backtracking to the last star
    function automatic bit glob_verdict();
        int         p;
        int         v;
        int         star_at;
        int         star_from;
        bit         have_star;
        logic [7:0] pc;
        p         = 0;
        v         = 0;
        star_at   = 0;
        star_from = 0;
        have_star = 1'b0;
        if (pat_len == 3 && pat_mem[0] == CH_STAR && pat_mem[1] == CH_DOT &&
            pat_mem[2] == CH_STAR)
        begin
            return 1'b1;
        end
        while (v < name_len)
        begin
            pc = (p < pat_len) ? to_lower(pat_mem[p]) : 8'h00;
            if (p < pat_len && (pc == CH_QMARK || pc == to_lower(name_mem[v])))
            begin
                v++;
                p++;
            end
            else if (p < pat_len && pc == CH_STAR)
            begin
                star_at   = p;
                p++;
                star_from = v;
                have_star = 1'b1;
            end
            else if (have_star)
            begin
                p = star_at + 1;
                star_from++;
                v = star_from;
            end
            else
            begin
                return 1'b0;
            end
        end
        // trailing stars match the empty rest
        while (p < pat_len && pat_mem[p] == CH_STAR)
        begin
            p++;
        end
        return p == pat_len;
    endfunction

    // Apply one accepted transfer to the shadow state
    task automatic take_char(input logic k, input logic [7:0] c, input logic nc,
                             input logic l);
        verdict_t vd;
        if (k == KIND_PATTERN)
        begin
            if (!pat_open)
            begin
                pat_len  = 0;
                pat_ovf  = 1'b0;
                pat_open = 1'b1;
            end
            if (!nc)
            begin
                if (pat_len < PATTERN_DEPTH)
                begin
                    pat_mem[pat_len] = c;
                    pat_len++;
                end
                else
                begin
                    pat_ovf = 1'b1;
                end
            end
            if (l)
            begin
                pat_open = 1'b0;
            end
        end
        else
        begin
            if (!name_open)
            begin
                name_len  = 0;
                name_ovf  = 1'b0;
                name_open = 1'b1;
            end
            if (!nc)
            begin
                if (name_len < NAME_DEPTH)
                begin
                    name_mem[name_len] = c;
                    name_len++;
                end
                else
                begin
                    name_ovf = 1'b1;
                end
            end
            if (l)
            begin
                name_open   = 1'b0;
                vd.overflow = pat_ovf || name_ovf;
                vd.matched  = !vd.overflow && glob_verdict();
                owed_verdicts = {owed_verdicts, vd};
            end
        end
    endtask

    // Check results first, then take the input transfer of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            pat_len   = 0;
            pat_open  = 1'b0;
            pat_ovf   = 1'b0;
            name_len  = 0;
            name_open = 1'b0;
            name_ovf  = 1'b0;
            owed_verdicts.delete();
            verdicts_owed <= 0;
            fail_count    <= errors;
        end
        else
        begin
            if (done)
            begin
                if (owed_verdicts.size() == 0)
                begin
                    $error("verdict with none owed: matched=%0b overflow=%0b",
                           matched, overflow);
                    errors++;
                end
                else
                begin
                    want = owed_verdicts.pop_front();
                    if (matched !== want.matched)
                    begin
                        $error("matched: expected %0b, got %0b", want.matched, matched);
                        errors++;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b", want.overflow,
                               overflow);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                take_char(kind, char_code, no_char, last);
            end
            verdicts_owed <= owed_verdicts.size();
            fail_count    <= errors;
        end
    end

endmodule

// ----- sim/tb_glob_wildcard_matcher.sv -----
module tb_glob_wildcard_matcher
    import gwm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int   PAT_DEPTH    = 64;
    localparam int   NAME_DEPTH   = 256;
    localparam int   ITEM_TARGET  = 1900;
    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_NAME    = 1'b1;

    typedef byte unsigned bytes_t[$];

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       kind = KIND_PATTERN;
    logic [7:0] char_code = 8'h00;
    logic       no_char = 1'b0;
    logic       last = 1'b0;
    logic       busy;
    logic       done;
    logic       matched;
    logic       overflow;
    int         fail_count;
    int         verdicts_owed;

    int         items_sent = 0;
    int         calm_left = 0;
    bytes_t     cur_pattern;
    bit         pattern_left_open = 1'b0;

    always #5 clk = ~clk;

    glob_wildcard_matcher #(
        .PATTERN_DEPTH(PAT_DEPTH),
        .NAME_DEPTH   (NAME_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .char_code(char_code),
        .no_char  (no_char),
        .last     (last),
        .done     (done),
        .matched  (matched),
        .overflow (overflow)
    );

    glob_match_checker #(
        .PATTERN_DEPTH(PAT_DEPTH),
        .NAME_DEPTH   (NAME_DEPTH)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .char_code    (char_code),
        .no_char      (no_char),
        .last         (last),
        .done         (done),
        .matched      (matched),
        .overflow     (overflow),
        .fail_count   (fail_count),
        .verdicts_owed(verdicts_owed)
    );

    // Mostly back-to-back or short gaps, now and then a long one or a calm run
    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    function automatic bytes_t str_bytes(input string s);
        bytes_t q;
        for (int i = 0; i < s.len(); i++)
        begin
            q = {q, s[i]};
        end
        return q;
    endfunction

    function automatic byte unsigned pattern_char();
        int    r;
        string pool;
        pool = "abAB";
        r = $urandom_range(0, 99);
        if (r < 20) return CH_STAR;
        if (r < 35) return CH_QMARK;
        if (r < 45) return CH_DOT;
        if (r < 90) return pool[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic byte unsigned name_char();
        int    r;
        string pool;
        pool = "abcAB";
        r = $urandom_range(0, 99);
        if (r < 10) return CH_DOT;
        if (r < 85) return pool[$urandom_range(0, 4)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Build a name likely to match the current pattern, with a rare mutation
    function automatic bytes_t name_like_pattern();
        bytes_t q;
        byte unsigned pc;
        for (int i = 0; i < cur_pattern.size(); i++)
        begin
            pc = cur_pattern[i];
            if (pc == CH_STAR)
            begin
                repeat ($urandom_range(0, 3)) q = {q, name_char()};
            end
            else if (pc == CH_QMARK)
            begin
                q = {q, name_char()};
            end
            else if (($urandom_range(0, 1) == 1) &&
                     ((pc >= 8'h41 && pc <= 8'h5A) || (pc >= 8'h61 && pc <= 8'h7A)))
            begin
                q = {q, pc ^ CASE_OFS};
            end
            else
            begin
                q = {q, pc};
            end
        end
        if (q.size() > 0 && $urandom_range(0, 7) == 0)
        begin
            q[$urandom_range(0, q.size() - 1)] = name_char();
        end
        if (q.size() > NAME_DEPTH + 4)
        begin
            q = q[0:NAME_DEPTH + 3];
        end
        return q;
    endfunction

    // One transfer: optional idle gap, then hold start until busy is low
    task automatic send_item(input logic k, input logic [7:0] c, input logic nc,
                             input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start     <= 1'b0;
            kind      <= 1'($urandom_range(0, 1));
            char_code <= 8'($urandom_range(0, 255));
            no_char   <= 1'($urandom_range(0, 1));
            last      <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start     <= 1'b1;
        kind      <= k;
        char_code <= c;
        no_char   <= nc;
        last      <= l;
        do @(posedge clk); while (busy);
        if (!nc || l)
        begin
            items_sent++;
        end
    endtask

    // Load a string; sometimes with empty items inside or a separate empty end
    task automatic send_string(input logic k, input bytes_t s, input bit terminate);
        bit split_end;
        split_end = terminate && (s.size() == 0 || $urandom_range(0, 9) == 0);
        for (int i = 0; i < s.size(); i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_item(k, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            send_item(k, s[i], 1'b0, terminate && !split_end && i == s.size() - 1);
        end
        if (split_end)
        begin
            send_item(k, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end
    endtask

    task automatic load_pattern(input bytes_t s, input bit terminate);
        if (!pattern_left_open)
        begin
            cur_pattern.delete();
        end
        foreach (s[i]) cur_pattern = {cur_pattern, s[i]};
        pattern_left_open = !terminate;
        send_string(KIND_PATTERN, s, terminate);
    endtask

    // Stimulus
    initial
    begin
        bytes_t s;
        int     len;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no pattern yet: only the empty name matches
        send_string(KIND_NAME, s, 1'b1);
        send_string(KIND_NAME, str_bytes("a"), 1'b1);
        // the catch-all pattern
        load_pattern(str_bytes("*.*"), 1'b1);
        send_string(KIND_NAME, str_bytes("X"), 1'b1);
        // case folding and single wildcard
        load_pattern(str_bytes("A?c"), 1'b1);
        send_string(KIND_NAME, str_bytes("aBC"), 1'b1);
        // name ends while the pattern is still open
        load_pattern(str_bytes("*z"), 1'b0);
        send_string(KIND_NAME, str_bytes("QZ"), 1'b1);
        send_item(KIND_PATTERN, 8'hFF, 1'b1, 1'b1);
        pattern_left_open = 1'b0;
        s = '{8'hFF, 8'h00};
        send_string(KIND_NAME, s, 1'b1);

        // random patterns, each followed by a few names
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                pattern_left_open = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                s.delete();
                if ($urandom_range(0, 19) == 0)
                begin
                    s = str_bytes($urandom_range(0, 1) ? "*.*" : "*.?");
                end
                else
                begin
                    len = ($urandom_range(0, 99) < 4) ? $urandom_range(60, 70)
                                                      : $urandom_range(0, 8);
                    repeat (len) s = {s, pattern_char()};
                end
                load_pattern(s, $urandom_range(0, 99) < 88);
            end
            repeat ($urandom_range(1, 5))
            begin
                if ($urandom_range(0, 99) < 55)
                begin
                    s = name_like_pattern();
                end
                else
                begin
                    s.delete();
                    len = ($urandom_range(0, 99) < 2) ? $urandom_range(250, 260)
                                                      : $urandom_range(0, 10);
                    repeat (len) s = {s, name_char()};
                end
                send_string(KIND_NAME, s, 1'b1);
            end
        end
        @(negedge clk);
        start <= 1'b0;

        // drain, then watch for stray results
        while (verdicts_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (fail_count == 0 && verdicts_owed == 0)
        begin
            $display("[glob_wildcard_matcher] OK");
        end
        else
        begin
            $display("[glob_wildcard_matcher] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #30_000_000;
        $display("[glob_wildcard_matcher] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/gwm_pkg.sv
design/gwm_ctrl.sv
design/gwm_dp.sv
design/glob_wildcard_matcher.sv
sim/glob_match_checker.sv
sim/tb_glob_wildcard_matcher.sv
